FILE: sv/mail_header_stream_parser_core_defines.svh
// Assertion macros shared by the mail header parser modules.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef MAIL_HEADER_STREAM_PARSER_CORE_DEFINES_SVH
`define MAIL_HEADER_STREAM_PARSER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check, disabled while reset is asserted.
`define MHSP_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked check that also holds during reset.
`define MHSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MHSP_ASSERT(lbl, clk, rstn, prop, msg)
`define MHSP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: sv/mhsp_pkg.sv
// Types, character constants and helper functions of the mail header parser.
// Depends on nothing; every other file but the assertion defines header imports it.
`default_nettype none

package mhsp_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_REJECT_HIGH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MUNGE_HIGH  = 2'd1;

	// Characters
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_X     = 8'h58;
	localparam logic [7:0] HIGH_MIN   = 8'h80;
	localparam logic [7:0] FTEXT_LO_MIN = 8'd33;
	localparam logic [7:0] FTEXT_LO_MAX = 8'd57;
	localparam logic [7:0] FTEXT_HI_MIN = 8'd59;
	localparam logic [7:0] FTEXT_HI_MAX = 8'd126;

	typedef enum logic [1:0] {
		STAT_RUNNING,
		STAT_END,
		STAT_BAD,
		STAT_8BIT
	} status_t;

	typedef enum logic [3:0] {
		PH_START,
		PH_FIELD,
		PH_SEP,
		PH_LEAD,
		PH_TEXT,
		PH_DOT,
		PH_CR,
		PH_NL,
		PH_DOTS,
		PH_END,
		PH_BAD,
		PH_HIGH
	} phase_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_DUMP,
		SQ_ITEM0,
		SQ_ITEM1
	} seq_state_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       in_value;
		logic       header_done;
		status_t    status;
	} item_t;

	localparam item_t ITEM_IDLE = '0;

	// Controller to datapath
	typedef struct packed {
		logic       store_first;
		logic       store_append;
		logic [7:0] wr_byte;
		logic       dump_start;
		logic       load_item;
		item_t      item;
		logic       item_last;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic reject_high;
		logic munge_high;
		logic name_full;
		logic dump_done;
		logic out_free;
	} dp_stat_t;

	function automatic logic is_ftext(input logic [7:0] b);
		return ((b >= FTEXT_LO_MIN) && (b <= FTEXT_LO_MAX)) ||
			((b >= FTEXT_HI_MIN) && (b <= FTEXT_HI_MAX));
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return (b == CHAR_SPACE) || (b == CHAR_TAB);
	endfunction

	function automatic item_t mk_emit(input logic [7:0] b, input logic inval);
		item_t it;
		it = ITEM_IDLE;
		it.out_byte   = b;
		it.byte_valid = 1'b1;
		it.in_value   = inval;
		return it;
	endfunction

	function automatic item_t mk_halt(input status_t code);
		item_t it;
		it = ITEM_IDLE;
		it.status = code;
		return it;
	endfunction

	function automatic item_t mk_done();
		item_t it;
		it = ITEM_IDLE;
		it.header_done = 1'b1;
		return it;
	endfunction

	function automatic phase_t halt_phase(input status_t code);
		phase_t ph;
		unique case (code)
			STAT_END:  ph = PH_END;
			STAT_8BIT: ph = PH_HIGH;
			default:   ph = PH_BAD;
		endcase
		return ph;
	endfunction

endpackage

`default_nettype wire

FILE: sv/mhsp_if.sv
// Channel interfaces of the mail header parser: input bytes, results, config writes.
// Depends on mhsp_pkg for the config index width.
`default_nettype none

interface mhsp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_input;

	modport source (output valid, output in_byte, output end_of_input, input ready);
	modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface mhsp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       in_value;
	logic       header_done;
	logic [1:0] status;
	logic       last;

	modport source (output valid, output out_byte, output byte_valid, output in_value,
		output header_done, output status, output last, input ready);
	modport sink (input valid, input out_byte, input byte_valid, input in_value,
		input header_done, input status, input last, output ready);
endinterface

interface mhsp_cfg_if;
	import mhsp_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic                 data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/mhsp_datapath.sv
// Datapath: config registers, name buffer memory with registered read, result register.
// Depends on mhsp_pkg; driven by mhsp_controller through dp_cmd_t.
`default_nettype none
`include "mail_header_stream_parser_core_defines.svh"

module mhsp_datapath #(
	parameter int NAME_MAX = 62
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [mhsp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic                           cfg_data,
	input  wire mhsp_pkg::dp_cmd_t              cmd,
	output mhsp_pkg::dp_stat_t                  stat,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output mhsp_pkg::item_t                     out_item,
	output logic                                out_last
);
	import mhsp_pkg::*;

	localparam int AW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
	localparam int LW = $clog2(NAME_MAX + 1);

	logic          reject_q;
	logic          munge_q;
	logic [7:0]    name_mem [NAME_MAX];
	logic [LW-1:0] name_len_q;
	logic [LW-1:0] rd_idx_q;
	logic          dump_act_q;
	logic [7:0]    rdata_s1;
	logic          rd_valid_s1;
	logic          out_valid_q;
	item_t         out_item_q;
	logic          out_last_q;

	logic          out_free;
	logic          rd_load;
	logic          rd_en;
	logic          dump_done;
	logic          wr_en;
	logic [AW-1:0] wr_addr;

	assign out_free  = !out_valid_q || out_ready;
	assign rd_load   = rd_valid_s1 && out_free;
	assign rd_en     = dump_act_q && (rd_idx_q != name_len_q) && (!rd_valid_s1 || rd_load);
	assign dump_done = dump_act_q && (rd_idx_q == name_len_q) && !rd_valid_s1;
	assign wr_en     = cmd.store_first || cmd.store_append;
	assign wr_addr   = cmd.store_first ? '0 : name_len_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reject_q <= 1'b0;
			munge_q  <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == REG_REJECT_HIGH) begin
				reject_q <= cfg_data;
			end
			if (cfg_index == REG_MUNGE_HIGH) begin
				munge_q <= cfg_data;
			end
		end
	end

	// Name buffer: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			name_mem[wr_addr] <= cmd.wr_byte;
		end
		if (rd_en) begin
			rdata_s1 <= name_mem[rd_idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_len_q  <= '0;
			rd_idx_q    <= '0;
			dump_act_q  <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (cmd.store_first) begin
				name_len_q <= LW'(1);
			end else if (cmd.store_append) begin
				name_len_q <= name_len_q + LW'(1);
			end
			if (cmd.dump_start) begin
				rd_idx_q   <= '0;
				dump_act_q <= 1'b1;
			end else begin
				if (rd_en) begin
					rd_idx_q <= rd_idx_q + LW'(1);
				end
				if (dump_done) begin
					dump_act_q <= 1'b0;
				end
			end
			if (rd_en) begin
				rd_valid_s1 <= 1'b1;
			end else if (rd_load) begin
				rd_valid_s1 <= 1'b0;
			end
		end
	end

	// Result register: name bytes during a dump, controller items otherwise
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= rd_load || cmd.load_item;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_load) begin
			out_item_q <= mk_emit(rdata_s1, 1'b0);
			out_last_q <= 1'b0;
		end else if (cmd.load_item && out_free) begin
			out_item_q <= cmd.item;
			out_last_q <= cmd.item_last;
		end
	end

	always_comb begin
		stat.reject_high = reject_q;
		stat.munge_high  = munge_q;
		stat.name_full   = (name_len_q >= LW'(NAME_MAX));
		stat.dump_done   = dump_done;
		stat.out_free    = out_free;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign out_last  = out_last_q;

	`MHSP_ASSERT(a_len_bound, clk, arst_n, name_len_q <= LW'(NAME_MAX), "name length past buffer")
	`MHSP_ASSERT(a_rd_in_dump, clk, arst_n, rd_valid_s1 |-> dump_act_q, "read data outside dump")
	`MHSP_ASSERT(a_one_loader, clk, arst_n, !(rd_valid_s1 && cmd.load_item),
		"item load collides with name byte")
	`MHSP_ASSERT(a_dump_len, clk, arst_n, $rose(dump_act_q) |-> (name_len_q != '0),
		"dump of an empty name")

endmodule

`default_nettype wire

FILE: sv/mhsp_controller.sv
// Controller: parser phase, per-byte decode and sequencing of result beats.
// Depends on mhsp_pkg; commands mhsp_datapath through dp_cmd_t.
`default_nettype none
`include "mail_header_stream_parser_core_defines.svh"

module mhsp_controller (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         in_byte,
	input  wire logic               end_of_input,
	input  wire mhsp_pkg::dp_stat_t stat,
	output mhsp_pkg::dp_cmd_t       cmd
);
	import mhsp_pkg::*;

	seq_state_t state_q, state_d;
	phase_t     phase_q;
	item_t      item0_q;
	item_t      item1_q;
	logic       item1_vld_q;

	logic       accept;
	logic       b_crlf;
	logic       b_blank;
	logic       b_ftext;

	// Start-of-field decode
	phase_t     start_next;
	logic       start_store;
	logic       start_has_item;
	item_t      start_item;
	// Value text decode
	phase_t     text_next;
	item_t      text_item0;
	item_t      text_item1;
	logic       text_two;
	// Plan for the accepted beat
	phase_t     pl_next;
	logic       pl_store_first;
	logic       pl_store_append;
	logic       pl_dump;
	item_t      pl_item0;
	item_t      pl_item1;
	logic       pl_item1_vld;

	assign in_ready = (state_q == SQ_IDLE);
	assign accept   = in_valid && in_ready;
	assign b_crlf   = (in_byte == CHAR_CR) || (in_byte == CHAR_LF);
	assign b_blank  = is_blank(in_byte);
	assign b_ftext  = is_ftext(in_byte);

	always_comb begin
		start_next     = PH_FIELD;
		start_store    = 1'b0;
		start_has_item = 1'b0;
		start_item     = ITEM_IDLE;
		priority if (in_byte == CHAR_DOT) begin
			start_next  = PH_DOT;
			start_store = 1'b1;
		end else if (b_crlf) begin
			start_next     = PH_END;
			start_has_item = 1'b1;
			start_item     = mk_halt(STAT_END);
		end else if (!b_ftext) begin
			start_next     = PH_BAD;
			start_has_item = 1'b1;
			start_item     = mk_halt(STAT_BAD);
		end else begin
			start_store = 1'b1;
		end
	end

	always_comb begin
		text_next  = PH_TEXT;
		text_item0 = ITEM_IDLE;
		text_item1 = ITEM_IDLE;
		text_two   = 1'b0;
		priority if (b_crlf) begin
			text_item0 = mk_emit(CHAR_CR, 1'b0);
			text_item1 = mk_emit(CHAR_LF, 1'b0);
			text_two   = 1'b1;
			text_next  = (in_byte == CHAR_CR) ? PH_CR : PH_NL;
		end else if ((in_byte >= HIGH_MIN) && stat.reject_high) begin
			text_item0 = mk_halt(STAT_8BIT);
			text_next  = PH_HIGH;
		end else if ((in_byte >= HIGH_MIN) && stat.munge_high) begin
			text_item0 = mk_emit(CHAR_X, 1'b1);
		end else begin
			text_item0 = mk_emit(in_byte, 1'b1);
		end
	end

	always_comb begin
		pl_next         = phase_q;
		pl_store_first  = 1'b0;
		pl_store_append = 1'b0;
		pl_dump         = 1'b0;
		pl_item0        = ITEM_IDLE;
		pl_item1        = ITEM_IDLE;
		pl_item1_vld    = 1'b0;
		priority if (phase_q == PH_END) begin
			pl_item0 = mk_halt(STAT_END);
		end else if (phase_q == PH_BAD) begin
			pl_item0 = mk_halt(STAT_BAD);
		end else if (phase_q == PH_HIGH) begin
			pl_item0 = mk_halt(STAT_8BIT);
		end else if (end_of_input) begin
			if ((phase_q == PH_CR) || (phase_q == PH_NL)) begin
				pl_item0     = mk_done();
				pl_item1     = mk_halt(STAT_END);
				pl_item1_vld = 1'b1;
				pl_next      = PH_END;
			end else if (phase_q == PH_DOTS) begin
				pl_item0 = mk_halt(STAT_BAD);
				pl_next  = PH_BAD;
			end else begin
				pl_item0 = mk_halt(STAT_END);
				pl_next  = PH_END;
			end
		end else begin
			unique case (phase_q)
				PH_START: begin
					pl_next        = start_next;
					pl_store_first = start_store;
					if (start_has_item) begin
						pl_item0 = start_item;
					end
				end
				PH_FIELD, PH_DOT: begin
					priority if ((phase_q == PH_DOT) && b_crlf) begin
						pl_item0 = mk_halt(STAT_END);
						pl_next  = PH_END;
					end else if (b_blank || (in_byte == CHAR_COLON)) begin
						// flush the buffered name, then the separator
						pl_dump  = 1'b1;
						pl_item0 = mk_emit(in_byte, 1'b0);
						pl_next  = (in_byte == CHAR_COLON) ? PH_LEAD : PH_SEP;
					end else if (!b_ftext || stat.name_full) begin
						pl_item0 = mk_halt(STAT_BAD);
						pl_next  = PH_BAD;
					end else begin
						pl_store_append = 1'b1;
						pl_next         = PH_FIELD;
					end
				end
				PH_SEP: begin
					priority if (in_byte == CHAR_COLON) begin
						pl_item0 = mk_emit(in_byte, 1'b0);
						pl_next  = PH_LEAD;
					end else if (b_blank) begin
						pl_item0 = mk_emit(in_byte, 1'b0);
					end else if (in_byte == CHAR_DOT) begin
						pl_item0 = mk_emit(in_byte, 1'b0);
						pl_next  = PH_DOTS;
					end else begin
						pl_item0 = mk_halt(STAT_BAD);
						pl_next  = PH_BAD;
					end
				end
				PH_DOTS: begin
					if (in_byte == CHAR_DOT) begin
						pl_item0 = mk_emit(in_byte, 1'b0);
					end else begin
						pl_item0 = mk_halt(STAT_BAD);
						pl_next  = PH_BAD;
					end
				end
				PH_LEAD, PH_TEXT: begin
					if ((phase_q == PH_LEAD) && b_blank) begin
						pl_item0 = mk_emit(in_byte, 1'b0);
					end else begin
						pl_item0     = text_item0;
						pl_item1     = text_item1;
						pl_item1_vld = text_two;
						pl_next      = text_next;
					end
				end
				PH_CR, PH_NL: begin
					priority if ((phase_q == PH_CR) && (in_byte == CHAR_LF)) begin
						pl_next = PH_NL;
					end else if (b_blank) begin
						// folded line: keep the blank, stay in the value
						pl_item0 = mk_emit(in_byte, 1'b0);
						pl_next  = PH_TEXT;
					end else begin
						pl_item0       = mk_done();
						pl_item1       = start_item;
						pl_item1_vld   = start_has_item;
						pl_next        = start_next;
						pl_store_first = start_store;
					end
				end
				default: begin
					pl_item0 = mk_halt(STAT_BAD);
					pl_next  = halt_phase(STAT_BAD);
				end
			endcase
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SQ_IDLE: begin
				if (accept) begin
					priority if (pl_dump) begin
						state_d = SQ_DUMP;
					end else if (stat.out_free) begin
						state_d = pl_item1_vld ? SQ_ITEM1 : SQ_IDLE;
					end else begin
						state_d = SQ_ITEM0;
					end
				end
			end
			SQ_DUMP: begin
				if (stat.dump_done) begin
					state_d = SQ_ITEM0;
				end
			end
			SQ_ITEM0: begin
				if (stat.out_free) begin
					state_d = item1_vld_q ? SQ_ITEM1 : SQ_IDLE;
				end
			end
			SQ_ITEM1: begin
				if (stat.out_free) begin
					state_d = SQ_IDLE;
				end
			end
			default: state_d = SQ_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd              = '0;
		cmd.wr_byte      = in_byte;
		cmd.store_first  = accept && pl_store_first;
		cmd.store_append = accept && pl_store_append;
		cmd.dump_start   = accept && pl_dump;
		unique case (state_q)
			SQ_IDLE: begin
				cmd.load_item = accept && !pl_dump && stat.out_free;
				cmd.item      = pl_item0;
				cmd.item_last = !pl_item1_vld;
			end
			SQ_ITEM0: begin
				cmd.load_item = stat.out_free;
				cmd.item      = item0_q;
				cmd.item_last = !item1_vld_q;
			end
			SQ_ITEM1: begin
				cmd.load_item = stat.out_free;
				cmd.item      = item1_q;
				cmd.item_last = 1'b1;
			end
			default: begin
				cmd.load_item = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SQ_IDLE;
			phase_q     <= PH_START;
			item1_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				phase_q     <= pl_next;
				item1_vld_q <= pl_item1_vld;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item0_q <= pl_item0;
			item1_q <= pl_item1;
		end
	end

	`MHSP_ASSERT(a_stop_sticks, clk, arst_n,
		(phase_q == PH_END || phase_q == PH_BAD || phase_q == PH_HIGH) |=> $stable(phase_q),
		"parser left a stopped phase")
	`MHSP_ASSERT(a_dump_phase, clk, arst_n,
		(state_q == SQ_DUMP) |-> (phase_q == PH_SEP || phase_q == PH_LEAD),
		"name dump outside separator phase")
	`MHSP_ASSERT(a_item1_pending, clk, arst_n, (state_q == SQ_ITEM1) |-> item1_vld_q,
		"second beat sent without one queued")

endmodule

`default_nettype wire

FILE: sv/mail_header_stream_parser_core.sv
// Result beats are held in a registered output stage; the rates below hold while it is free.
// Throughput: one byte per cycle when it yields one beat; a byte that yields two
// (newline to CRLF, field end with a stop) holds the input until both are loaded; a name
// ended by blank or colon goes out one name byte per cycle from the buffer's read port.
// Reset (arst_n low): phase to name start, name length 0, config bits 0; buffer not cleared.
`default_nettype none

module mail_header_stream_parser_core #(
	parameter int NAME_MAX = 62
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mhsp_in_if.sink    in_ch,
	mhsp_out_if.source out_ch,
	mhsp_cfg_if.sink   cfg_ch
);
	import mhsp_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     ctl_in_ready;
	logic     out_valid;
	item_t    out_item;
	logic     out_last;
	logic     cfg_we;

	// Config writes are always taken
	assign cfg_ch.ready = 1'b1;
	assign cfg_we       = cfg_ch.valid;

	mhsp_controller u_ctl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_ch.valid),
		.in_ready     (ctl_in_ready),
		.in_byte      (in_ch.in_byte),
		.end_of_input (in_ch.end_of_input),
		.stat         (stat),
		.cmd          (cmd)
	);

	mhsp_datapath #(
		.NAME_MAX (NAME_MAX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_ch.index),
		.cfg_data  (cfg_ch.data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ch.ready),
		.out_item  (out_item),
		.out_last  (out_last)
	);

	assign in_ch.ready        = ctl_in_ready;
	assign out_ch.valid       = out_valid;
	assign out_ch.out_byte    = out_item.out_byte;
	assign out_ch.byte_valid  = out_item.byte_valid;
	assign out_ch.in_value    = out_item.in_value;
	assign out_ch.header_done = out_item.header_done;
	assign out_ch.status      = out_item.status;
	assign out_ch.last        = out_last;

endmodule

`default_nettype wire
